/* hdl/lapd_pkg.sv */
// Package for the LAPD I-frame sequence engine: word types, field codes,
// register map and configuration struct. No dependencies.
package lapd_pkg;

    localparam int SEQ_W  = 7;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef logic [SEQ_W-1:0] seq_t;

    // func codes
    localparam logic FUNC_RX = 1'b0;
    localparam logic FUNC_TX = 1'b1;

    // link_state codes
    localparam logic [1:0] LINK_MFE  = 2'd1;
    localparam logic [1:0] LINK_TREC = 2'd2;

    // response_kind codes
    localparam logic [1:0] RESP_NONE = 2'd0;
    localparam logic [1:0] RESP_RR   = 2'd1;
    localparam logic [1:0] RESP_RNR  = 2'd2;
    localparam logic [1:0] RESP_REJ  = 2'd3;

    // timer action codes
    localparam logic [1:0] TMR_NONE  = 2'd0;
    localparam logic [1:0] TMR_START = 2'd1;
    localparam logic [1:0] TMR_STOP  = 2'd2;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_TEI_ASSIGNED = 2'd0;
    localparam logic [1:0] REG_OWN_TEI      = 2'd1;
    localparam logic [1:0] REG_WINDOW_SIZE  = 2'd2;

    localparam seq_t WINDOW_RESET = 7'd1;

    typedef struct packed {
        logic       func;
        seq_t       frame_tei;
        seq_t       frame_ns;
        seq_t       frame_nr;
        logic       poll_bit;
        logic [1:0] link_state;
        logic       own_rx_busy;
        logic       peer_rx_busy;
        logic       reply_iframe_ready;
        logic       t200_running;
        logic       tx_queue_nonempty;
    } lapd_in_t;

    typedef struct packed {
        logic       deliver_data;
        logic       discard_frame;
        logic [1:0] response_kind;
        logic       response_final;
        logic       send_iframe;
        seq_t       tx_ns;
        seq_t       tx_nr;
        logic       retry_later;
        logic [1:0] t200_action;
        logic [1:0] t203_action;
        logic       nr_error;
        seq_t       ack_number;
    } lapd_out_t;

    typedef struct packed {
        logic tei_assigned;
        seq_t own_tei;
        seq_t window_size;
    } lapd_cfg_t;

endpackage

/* hdl/lapd_cfg_regs.sv */
// APB-style configuration registers of the LAPD sequence engine.
// Depends on lapd_pkg.
module lapd_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lapd_pkg::ADDR_W-1:0] paddr,
    input  logic [lapd_pkg::DATA_W-1:0] pwdata,
    output logic [lapd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output lapd_pkg::lapd_cfg_t         cfg
);
    import lapd_pkg::*;

    lapd_cfg_t  cfg_reg;
    lapd_cfg_t  cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_TEI_ASSIGNED: cfg_next.tei_assigned = pwdata[0];
                REG_OWN_TEI:      cfg_next.own_tei      = pwdata[SEQ_W-1:0];
                REG_WINDOW_SIZE:  cfg_next.window_size  = pwdata[SEQ_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TEI_ASSIGNED: prdata = {{(DATA_W-1){1'b0}}, cfg_reg.tei_assigned};
            REG_OWN_TEI:      prdata = {{(DATA_W-SEQ_W){1'b0}}, cfg_reg.own_tei};
            REG_WINDOW_SIZE:  prdata = {{(DATA_W-SEQ_W){1'b0}}, cfg_reg.window_size};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tei_assigned <= 1'b0;
            cfg_reg.own_tei      <= '0;
            cfg_reg.window_size  <= WINDOW_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hdl/lapd_seq_core.sv */
// Sequence state V(S), V(A), V(R), reject exception, and the per-word
// decision logic of the LAPD engine. Depends on lapd_pkg.
module lapd_seq_core (
    input  logic                clk,
    input  logic                rst_n,
    input  lapd_pkg::lapd_cfg_t cfg,
    input  lapd_pkg::lapd_in_t  item,
    input  logic                advance,
    output lapd_pkg::lapd_out_t res
);
    import lapd_pkg::*;

    seq_t vs_reg, vs_next;
    seq_t va_reg, va_next;
    seq_t vr_reg, vr_next;
    logic rej_reg, rej_next;

    logic closed;
    logic tei_ok;
    logic link_ok;
    logic nr_ok;
    seq_t nr_off;
    seq_t nr_span;

    // window closed when V(S) = V(A) + k, modulo 128
    assign closed  = (vs_reg == seq_t'(va_reg + cfg.window_size));
    assign tei_ok  = cfg.tei_assigned && (item.frame_tei == cfg.own_tei);
    assign link_ok = (item.link_state == LINK_MFE) || (item.link_state == LINK_TREC);
    assign nr_off  = seq_t'(item.frame_nr - va_reg);
    assign nr_span = seq_t'(vs_reg - va_reg);
    assign nr_ok   = (nr_off <= nr_span);

    always_comb
    begin
        res      = '0;
        vs_next  = vs_reg;
        va_next  = va_reg;
        vr_next  = vr_reg;
        rej_next = rej_reg;

        if (item.func == FUNC_TX)
        begin
            if (item.peer_rx_busy || closed)
            begin
                res.retry_later = item.tx_queue_nonempty;
            end
            else if (item.tx_queue_nonempty)
            begin
                res.send_iframe = 1'b1;
                res.tx_ns       = vs_reg;
                res.tx_nr       = vr_reg;
                vs_next         = seq_t'(vs_reg + 7'd1);
                if (!item.t200_running)
                begin
                    res.t203_action = TMR_STOP;
                    res.t200_action = TMR_START;
                end
            end
        end
        else if (!tei_ok || !link_ok)
        begin
            res.discard_frame = 1'b1;
        end
        else
        begin
            res.ack_number = item.frame_nr;

            if (item.own_rx_busy)
            begin
                res.discard_frame = 1'b1;
                if (item.poll_bit)
                begin
                    res.response_kind  = RESP_RNR;
                    res.response_final = 1'b1;
                end
            end
            else if (item.frame_ns == vr_reg)
            begin
                vr_next          = seq_t'(vr_reg + 7'd1);
                rej_next         = 1'b0;
                res.deliver_data = 1'b1;
                if (!item.reply_iframe_ready)
                begin
                    res.response_kind  = RESP_RR;
                    res.response_final = item.poll_bit;
                end
            end
            else
            begin
                res.discard_frame = 1'b1;
                if (rej_reg)
                begin
                    if (item.poll_bit)
                    begin
                        res.response_kind  = RESP_RR;
                        res.response_final = 1'b1;
                    end
                end
                else
                begin
                    rej_next           = 1'b1;
                    res.response_kind  = RESP_REJ;
                    res.response_final = item.poll_bit;
                end
            end

            if (nr_ok)
            begin
                if ((item.link_state == LINK_TREC) || item.peer_rx_busy)
                begin
                    va_next = item.frame_nr;
                end
                else if (item.frame_nr == vs_reg)
                begin
                    va_next         = item.frame_nr;
                    res.t200_action = TMR_STOP;
                    res.t203_action = TMR_START;
                end
                else if (item.frame_nr != va_reg)
                begin
                    va_next         = item.frame_nr;
                    res.t200_action = TMR_START;
                end
            end
            else
            begin
                res.nr_error = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vs_reg  <= '0;
            va_reg  <= '0;
            vr_reg  <= '0;
            rej_reg <= 1'b0;
        end
        else if (advance)
        begin
            vs_reg  <= vs_next;
            va_reg  <= va_next;
            vr_reg  <= vr_next;
            rej_reg <= rej_next;
        end
    end

endmodule

/* hdl/lapd_iframe_sequence_engine.sv */
// Top level of the LAPD I-frame sequence engine: word registers on both
// sides, configuration port and sequence core. Depends on lapd_pkg,
// lapd_cfg_regs and lapd_seq_core.
//
// One word in, one word out, one word per clock sustained while
// result_ready stays high. A word taken on item_valid/item_ready sits in
// the input register, passes the decision logic of lapd_seq_core (a few
// 7-bit compares, subtracts and increments) and lands in the result
// register, at which edge V(S), V(A), V(R) and the reject exception are
// updated too. result_valid rises at the edge after the one that takes
// the word, when the output side is not stalled. The next word sees the
// state left by the previous one, so back-to-back words are handled
// exactly as a serial stream. When result_ready is low the result
// register holds, and one more word may still be taken into the input
// register before item_ready drops.
// Configuration (tei_assigned at 0x0, own_tei at 0x4, window_size at 0x8)
// is written over the APB-style port with pready tied high; write it only
// while no word is in flight. Reset leaves window_size at 1 and all
// sequence variables at zero.
module lapd_iframe_sequence_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  lapd_pkg::lapd_in_t          item,
    output logic                        result_valid,
    input  logic                        result_ready,
    output lapd_pkg::lapd_out_t         result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lapd_pkg::ADDR_W-1:0] paddr,
    input  logic [lapd_pkg::DATA_W-1:0] pwdata,
    output logic [lapd_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import lapd_pkg::*;

    lapd_cfg_t cfg;
    lapd_in_t  item_reg;
    logic      item_valid_reg;
    lapd_out_t res_next;
    lapd_out_t result_reg;
    logic      result_valid_reg;
    logic      advance;

    // word moves from input register to result register
    assign advance      = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !item_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    lapd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lapd_seq_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (item_reg),
        .advance (advance),
        .res     (res_next)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                item_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= res_next;
        end
    end

endmodule

/* hdl/lapd_checker.sv */
// Port-level checks for the LAPD sequence engine, bound to the top level.
// Depends on lapd_pkg and lapd_iframe_sequence_engine.
module lapd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                result_valid,
    input logic                result_ready,
    input lapd_pkg::lapd_out_t result
);
    import lapd_pkg::*;

    logic res_fire;
    logic tx_fire;

    assign res_fire = result_valid && result_ready;
    assign tx_fire  = res_fire && result.send_iframe;

    // no result word while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result_valid high during reset");

    // stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // back-to-back transmitted frames carry consecutive N(S)
    a_ns_step: assert property (@(posedge clk) disable iff (!rst_n)
        tx_fire ##1 tx_fire |-> result.tx_ns == seq_t'($past(result.tx_ns) + 7'd1))
        else $error("N(S) of consecutive sent frames not consecutive");

    // a transmit word never carries receive-side actions
    a_tx_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.send_iframe |->
            !result.deliver_data && !result.discard_frame
            && result.response_kind == RESP_NONE && !result.nr_error)
        else $error("sent frame mixed with receive actions");

endmodule

bind lapd_iframe_sequence_engine lapd_checker u_lapd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

/* tb/lapd_seq_checker.sv */
// Checker for the LAPD I-frame sequence engine: watches the word channels and
// the register port, predicts every result word and compares it field by field.
// Depends on lapd_pkg.
module lapd_seq_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  logic                        item_ready,
    input  lapd_pkg::lapd_in_t          item,
    input  logic                        result_valid,
    input  logic                        result_ready,
    input  lapd_pkg::lapd_out_t         result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lapd_pkg::ADDR_W-1:0] paddr,
    input  logic [lapd_pkg::DATA_W-1:0] pwdata,
    input  logic                        pready,
    output int                          fail_count,
    output int                          words_checked,
    output int                          in_flight,
    output lapd_pkg::seq_t              seen_send_seq,
    output lapd_pkg::seq_t              seen_ack_seq
);
    timeunit 1ns;
    timeprecision 1ps;

    import lapd_pkg::*;

    // link variables V(S), V(A), V(R) and the reject exception
    seq_t      vs;
    seq_t      va;
    seq_t      vr;
    logic      rej_exc;
    logic      cfg_tei_on;
    seq_t      cfg_tei;
    seq_t      cfg_k;
    lapd_out_t expected_q[$];

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
            fail_count++;
        end
    endtask

    // Applies one word to the link variables and works out its result word.
    task automatic advance_link(input lapd_in_t w, output lapd_out_t r);
        seq_t off;
        seq_t span;
        seq_t lim;
        r = '0;
        if (w.func == FUNC_TX) begin
            lim = va + cfg_k;
            if (w.peer_rx_busy || vs == lim) begin
                r.retry_later = w.tx_queue_nonempty;
            end
            else if (w.tx_queue_nonempty) begin
                r.send_iframe = 1'b1;
                r.tx_ns       = vs;
                r.tx_nr       = vr;
                vs            = vs + 1'b1;
                if (!w.t200_running) begin
                    r.t203_action = TMR_STOP;
                    r.t200_action = TMR_START;
                end
            end
        end
        else if (!(cfg_tei_on && w.frame_tei == cfg_tei)) begin
            r.discard_frame = 1'b1;
        end
        else if (w.link_state != LINK_MFE && w.link_state != LINK_TREC) begin
            r.discard_frame = 1'b1;
        end
        else begin
            r.ack_number = w.frame_nr;
            if (w.own_rx_busy) begin
                r.discard_frame = 1'b1;
                if (w.poll_bit) begin
                    r.response_kind  = RESP_RNR;
                    r.response_final = 1'b1;
                end
            end
            else if (w.frame_ns == vr) begin
                vr             = vr + 1'b1;
                rej_exc        = 1'b0;
                r.deliver_data = 1'b1;
                if (!w.reply_iframe_ready) begin
                    r.response_kind  = RESP_RR;
                    r.response_final = w.poll_bit;
                end
            end
            else begin
                r.discard_frame = 1'b1;
                if (rej_exc) begin
                    if (w.poll_bit) begin
                        r.response_kind  = RESP_RR;
                        r.response_final = 1'b1;
                    end
                end
                else begin
                    rej_exc          = 1'b1;
                    r.response_kind  = RESP_REJ;
                    r.response_final = w.poll_bit;
                end
            end

            // N(R) valid when it lies between V(A) and V(S), modulo 128
            off  = w.frame_nr - va;
            span = vs - va;
            if (off <= span) begin
                if (w.link_state == LINK_TREC || w.peer_rx_busy) begin
                    va = w.frame_nr;
                end
                else if (w.frame_nr == vs) begin
                    va            = w.frame_nr;
                    r.t200_action = TMR_STOP;
                    r.t203_action = TMR_START;
                end
                else if (w.frame_nr != va) begin
                    va            = w.frame_nr;
                    r.t200_action = TMR_START;
                end
            end
            else begin
                r.nr_error = 1'b1;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : track
        lapd_out_t pred;
        lapd_out_t want;
        if (!rst_n) begin
            vs            = '0;
            va            = '0;
            vr            = '0;
            rej_exc       = 1'b0;
            cfg_tei_on    = 1'b0;
            cfg_tei       = '0;
            cfg_k         = WINDOW_RESET;
            fail_count    = 0;
            words_checked = 0;
            expected_q.delete();
            in_flight     <= 0;
            seen_send_seq <= '0;
            seen_ack_seq  <= '0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_TEI_ASSIGNED: cfg_tei_on = pwdata[0];
                    REG_OWN_TEI:      cfg_tei    = pwdata[SEQ_W-1:0];
                    REG_WINDOW_SIZE:  cfg_k      = pwdata[SEQ_W-1:0];
                    default:          ;
                endcase
            end
            if (item_valid && item_ready) begin
                advance_link(item, pred);
                expected_q.push_back(pred);
            end
            if (result_valid && result_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t ns: result word arrived, expected none, got %h", $time, result);
                    fail_count++;
                end
                else begin
                    want = expected_q.pop_front();
                    check_field("deliver_data", want.deliver_data, result.deliver_data);
                    check_field("discard_frame", want.discard_frame, result.discard_frame);
                    check_field("response_kind", want.response_kind, result.response_kind);
                    check_field("response_final", want.response_final, result.response_final);
                    check_field("send_iframe", want.send_iframe, result.send_iframe);
                    check_field("tx_ns", want.tx_ns, result.tx_ns);
                    check_field("tx_nr", want.tx_nr, result.tx_nr);
                    check_field("retry_later", want.retry_later, result.retry_later);
                    check_field("t200_action", want.t200_action, result.t200_action);
                    check_field("t203_action", want.t203_action, result.t203_action);
                    check_field("nr_error", want.nr_error, result.nr_error);
                    check_field("ack_number", want.ack_number, result.ack_number);
                    words_checked++;
                end
            end
            in_flight     <= expected_q.size();
            seen_send_seq <= vs;
            seen_ack_seq  <= va;
        end
    end

endmodule

/* tb/testbench.sv */
// Top of the LAPD I-frame sequence engine testbench: clock, reset, stimulus,
// register writes and verdict. Depends on lapd_pkg, lapd_seq_checker and the
// lapd_iframe_sequence_engine RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lapd_pkg::*;

    // link states with no name in the package: down, and the unused code
    localparam logic [1:0] LINK_DOWN   = 2'd0;
    localparam logic [1:0] LINK_UNUSED = 2'd3;

    // cycles without any handshake before the run is declared hung; the
    // longest legitimate quiet spell is a long sender gap meeting a long
    // receiver stall
    localparam int IDLE_LIMIT = 4000;

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_ready;
    lapd_in_t            item;
    logic                result_valid;
    logic                result_ready;
    lapd_out_t           result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int                  fail_count;
    int                  words_checked;
    int                  in_flight;
    seq_t                seen_send_seq;
    seq_t                seen_ack_seq;

    // Stimulus-side bookkeeping, acting as the peer: the register settings in
    // force, the N(S) the block will take as in sequence, and the N(R) of the
    // last frame that got past the TEI and link-state checks.
    logic                cfg_tei_on;
    seq_t                cfg_tei;
    seq_t                cfg_k;
    seq_t                rx_next;
    seq_t                last_nr;
    logic                prev_processed;
    bit                  calm;
    int                  idle_cycles = 0;
    int                  words_sent = 0;
    int                  settings_used = 0;

    lapd_iframe_sequence_engine u_top (
        .clk, .rst_n,
        .item_valid, .item_ready, .item,
        .result_valid, .result_ready, .result,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    lapd_seq_checker u_checker (
        .clk, .rst_n,
        .item_valid, .item_ready, .item,
        .result_valid, .result_ready, .result,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .fail_count, .words_checked, .in_flight, .seen_send_seq, .seen_ack_seq
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: any handshake on either word channel or the register port
    // counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready)
            || (psel && penable && pready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
                     IDLE_LIMIT, in_flight);
            $display("testbench: errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side back-pressure. Mostly ready, short stalls now and then, the
    // odd long one; held high throughout a calm phase.
    initial
    begin : sink
        int hold;
        int roll;
        hold = 0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (calm)
            begin
                result_ready <= 1'b1;
            end
            else if (hold > 0)
            begin
                hold--;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 60)
                begin
                    result_ready <= 1'b1;
                    hold = $urandom_range(0, 12);
                end
                else if (roll < 93)
                begin
                    result_ready <= 1'b0;
                    hold = $urandom_range(0, 3);
                end
                else
                begin
                    result_ready <= 1'b0;
                    hold = $urandom_range(10, 30);
                end
            end
        end
    end

    // Sender gap before a word: none about half the time, a long one rarely.
    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic lapd_in_t rx_word(input seq_t tei, input seq_t ns, input seq_t nr,
                                         input logic poll, input logic [1:0] link,
                                         input logic busy_near, input logic busy_far,
                                         input logic reply);
        lapd_in_t w;
        w                    = '0;
        w.func               = FUNC_RX;
        w.frame_tei          = tei;
        w.frame_ns           = ns;
        w.frame_nr           = nr;
        w.poll_bit           = poll;
        w.link_state         = link;
        w.own_rx_busy        = busy_near;
        w.peer_rx_busy       = busy_far;
        w.reply_iframe_ready = reply;
        return w;
    endfunction

    function automatic lapd_in_t tx_word(input logic queued, input logic busy_far,
                                         input logic t200_run);
        lapd_in_t w;
        w                   = '0;
        w.func              = FUNC_TX;
        w.tx_queue_nonempty = queued;
        w.peer_rx_busy      = busy_far;
        w.t200_running      = t200_run;
        return w;
    endfunction

    // Random word. Most are well-formed: received frames for our own TEI with
    // the expected N(S) and an N(R) inside the acknowledgement window, or
    // transmit requests with a frame queued. The rest are raw random bits.
    // The checker's V(A)/V(S) snapshot lags by the word just taken, so when
    // that word was a processed frame its N(R) stands in for V(A); V(S) only
    // grows, so a stale copy still bounds a valid N(R).
    function automatic lapd_in_t draw_word();
        lapd_in_t    w;
        logic [31:0] bits;
        seq_t        base;
        seq_t        span;
        int          roll;
        bits = $urandom;
        w    = bits[$bits(lapd_in_t)-1:0];
        roll = $urandom_range(0, 99);
        if (roll < 45)
        begin
            base           = prev_processed ? last_nr : seen_ack_seq;
            span           = seen_send_seq - base;
            w.func         = FUNC_RX;
            w.frame_tei    = cfg_tei;
            w.link_state   = ($urandom_range(0, 4) == 0) ? LINK_TREC : LINK_MFE;
            w.own_rx_busy  = ($urandom_range(0, 9) == 0);
            w.peer_rx_busy = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) != 0)
                w.frame_ns = rx_next;
            w.frame_nr     = base + seq_t'($urandom_range(0, span));
        end
        else if (roll < 80)
        begin
            w.func              = FUNC_TX;
            w.tx_queue_nonempty = ($urandom_range(0, 7) != 0);
            w.peer_rx_busy      = ($urandom_range(0, 7) == 0);
        end
        return w;
    endfunction

    // Offers one word and returns at the edge that takes it. Valid stays high
    // on return so that the next word can follow back to back.
    task automatic push_word(input lapd_in_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= w;
        item_valid <= 1'b1;
        prev_processed = 1'b0;
        if (w.func == FUNC_RX && cfg_tei_on && w.frame_tei == cfg_tei
            && (w.link_state == LINK_MFE || w.link_state == LINK_TREC))
        begin
            if (!w.own_rx_busy && w.frame_ns == rx_next)
                rx_next = rx_next + 1'b1;
            prev_processed = 1'b1;
            last_nr        = w.frame_nr;
        end
        do @(posedge clk); while (!item_ready);
        words_sent++;
    endtask

    // Drops valid and waits until every predicted word has come out of the
    // two-stage pipe.
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all three registers back to back; psel stays up between them.
    task automatic load_settings(input logic tei_on, input seq_t tei, input seq_t k);
        for (int i = 0; i < 3; i++)
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            case (i)
                0:
                begin
                    paddr  <= {REG_TEI_ASSIGNED, 2'b00};
                    pwdata <= DATA_W'(tei_on);
                end
                1:
                begin
                    paddr  <= {REG_OWN_TEI, 2'b00};
                    pwdata <= DATA_W'(tei);
                end
                default:
                begin
                    paddr  <= {REG_WINDOW_SIZE, 2'b00};
                    pwdata <= DATA_W'(k);
                end
            endcase
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_tei_on = tei_on;
        cfg_tei    = tei;
        cfg_k      = k;
        settings_used++;
    endtask

    task automatic run_phase(input logic tei_on, input seq_t tei, input seq_t k,
                             input int count, input bit steady);
        settle();
        load_settings(tei_on, tei, k);
        calm = steady;
        repeat (count) push_word(draw_word());
        calm = 1'b0;
    endtask

    initial
    begin : stimulus
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        cfg_tei_on     = 1'b0;
        cfg_tei        = '0;
        cfg_k          = WINDOW_RESET;
        rx_next        = '0;
        last_nr        = '0;
        prev_processed = 1'b0;
        calm           = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: no TEI yet, window of one.
        push_word(rx_word(7'd0, 7'd0, 7'd0, 1'b1, LINK_MFE, 1'b0, 1'b0, 1'b0));
        push_word(tx_word(1'b1, 1'b0, 1'b0));   // window open: sends N(S)=0
        push_word(tx_word(1'b1, 1'b0, 1'b1));   // window now shut: retry
        push_word(tx_word(1'b0, 1'b0, 1'b0));   // shut, nothing queued: no retry
        settle();
        load_settings(1'b1, 7'd127, 7'd127);

        // Filtering ahead of sequence handling
        push_word(rx_word(7'd0, 7'd0, 7'd0, 1'b1, LINK_MFE, 1'b0, 1'b0, 1'b0));
        push_word(rx_word(7'd127, 7'd0, 7'd0, 1'b1, LINK_DOWN, 1'b0, 1'b0, 1'b0));
        push_word(rx_word(7'd127, 7'd0, 7'd0, 1'b1, LINK_UNUSED, 1'b0, 1'b0, 1'b0));
        // own receiver busy, with and without poll
        push_word(rx_word(7'd127, 7'd0, 7'd0, 1'b1, LINK_MFE, 1'b1, 1'b0, 1'b0));
        push_word(rx_word(7'd127, 7'd0, 7'd0, 1'b0, LINK_MFE, 1'b1, 1'b0, 1'b0));
        // in sequence, N(R) = V(S) acknowledges everything
        push_word(rx_word(7'd127, 7'd0, 7'd1, 1'b1, LINK_MFE, 1'b0, 1'b0, 1'b0));
        // in sequence with an upper-layer reply pending: no RR
        push_word(rx_word(7'd127, 7'd1, 7'd1, 1'b0, LINK_MFE, 1'b0, 1'b0, 1'b1));
        // transmit: empty queue, then two sends with T200 idle and running
        push_word(tx_word(1'b0, 1'b0, 1'b0));
        push_word(tx_word(1'b1, 1'b0, 1'b0));
        push_word(tx_word(1'b1, 1'b0, 1'b1));
        // out of sequence: REJ, then RR on poll only while the exception holds
        push_word(rx_word(7'd127, 7'd5, 7'd1, 1'b0, LINK_MFE, 1'b0, 1'b0, 1'b0));
        push_word(rx_word(7'd127, 7'd5, 7'd1, 1'b1, LINK_MFE, 1'b0, 1'b0, 1'b0));
        push_word(rx_word(7'd127, 7'd5, 7'd1, 1'b0, LINK_MFE, 1'b0, 1'b0, 1'b0));
        // in sequence, partial acknowledgement restarts T200
        push_word(rx_word(7'd127, 7'd2, 7'd2, 1'b1, LINK_MFE, 1'b0, 1'b0, 1'b0));
        // N(R) far outside the window
        push_word(rx_word(7'd127, 7'd9, 7'd100, 1'b1, LINK_MFE, 1'b0, 1'b0, 1'b0));
        // timer recovery and peer busy take N(R) without timer actions
        push_word(rx_word(7'd127, 7'd3, 7'd3, 1'b0, LINK_TREC, 1'b0, 1'b0, 1'b0));
        push_word(rx_word(7'd127, 7'd4, 7'd3, 1'b1, LINK_MFE, 1'b0, 1'b1, 1'b0));
        // peer busy on transmit, queued and not
        push_word(tx_word(1'b1, 1'b1, 1'b0));
        push_word(tx_word(1'b0, 1'b1, 1'b0));

        // Random phases across the settings range: a typical window, both
        // extremes of TEI and window, a calm stretch with no idling at all,
        // a zero window (out of range but taken as written) and a spell with
        // no TEI assigned.
        run_phase(1'b1, seq_t'($urandom_range(1, 126)), 7'd7, 320, 1'b0);
        run_phase(1'b1, 7'd127, 7'd127, 320, 1'b0);
        run_phase(1'b1, 7'd0, 7'd1, 320, 1'b1);
        run_phase(1'b1, seq_t'($urandom), 7'd0, 200, 1'b0);
        run_phase(1'b0, seq_t'($urandom), 7'd5, 120, 1'b0);
        run_phase(1'b1, seq_t'($urandom), seq_t'($urandom_range(1, 127)), 570, 1'b0);
        settle();

        $display("run covered %0d words under %0d register settings", words_sent,
                 settings_used);
        $display("%0d result words compared, %0d field mismatches", words_checked,
                 fail_count);
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

/* lapd_iframe_sequence_engine.f */
hdl/lapd_pkg.sv
hdl/lapd_cfg_regs.sv
hdl/lapd_seq_core.sv
hdl/lapd_iframe_sequence_engine.sv
hdl/lapd_checker.sv
tb/lapd_seq_checker.sv
tb/testbench.sv
